/* rtl/core/bcic_pkg.sv */
`default_nettype none

package bcic_pkg;

    localparam int WORD_W     = 14;               // one-bit samples per input word
    localparam int HALF_W     = WORD_W / 2;       // even (or odd) samples per word
    localparam int CNT_W      = $clog2(HALF_W + 1);
    localparam int FRONT_W    = 7;                // front section register width
    localparam int SAMPLE_W   = 16;               // output sample width
    localparam int PHASE_W    = 16;               // phase counter / ratio width
    localparam int N_STAGES   = 4;                // cic order
    localparam int ACC_WIDTH_DEF = 34;
    localparam int OUT_SHIFT_DEF = 16;
    localparam logic [PHASE_W-1:0] RATIO_RESET = PHASE_W'(1);

    // 2 * (ones in even bits - ones in odd bits), wrapped to the front width
    function automatic logic [FRONT_W-1:0] word_diff(input logic [WORD_W-1:0] w);
        logic [CNT_W-1:0] n_even;
        logic [CNT_W-1:0] n_odd;
        n_even = '0;
        n_odd  = '0;
        for (int k = 0; k < HALF_W; k++) begin
            n_even = n_even + CNT_W'(w[2*k]);
            n_odd  = n_odd  + CNT_W'(w[2*k+1]);
        end
        return FRONT_W'({n_even, 1'b0}) - FRONT_W'({n_odd, 1'b0});
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bitstream_cic_decimator.sv */
// four-stage cic decimator for a one-bit bitstream, fourteen samples per word
// throughput: one input word per cycle while m_tready holds, one result word per input
//   word; the pipeline has ten registers (input, front, four integrators, four combs)
// reset: aresetn is synchronous, active low; it empties the pipeline, clears the
//   integrators, comb delays, front section and phase counter, and sets the ratio to 1
`default_nettype none

module bitstream_cic_decimator import bcic_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF,   // integrator / comb wrap width
    parameter int OUT_SHIFT = OUT_SHIFT_DEF    // lowest accumulator bit of the output
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration: decimation ratio
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PHASE_W-1:0]  cfg_data,
    // input words
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,   // [13:0] sample_word, [15:14] zero
    // result words
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,   // [15:0] filtered_sample, [31:16] phase
    output logic                     m_tuser    // [0] sample_valid
);

    // pipeline stage numbering
    localparam int ST_IN    = 0;
    localparam int ST_FRONT = 1;
    localparam int ST_INT   = 2;                       // first integrator
    localparam int ST_COMB  = ST_INT + N_STAGES;       // first comb
    localparam int ST_OUT   = ST_COMB + N_STAGES - 1;  // last comb doubles as output
    localparam int N_ST     = ST_OUT + 1;
    // wide enough that the output slice never runs past the sign extension
    localparam int EXT_W    = (ACC_WIDTH > OUT_SHIFT + SAMPLE_W) ? ACC_WIDTH
                                                                 : OUT_SHIFT + SAMPLE_W;

    // ---------------- pipeline control ----------------
    // each stage holds one word; a stage takes a new word when it is empty or its
    // word moves on in the same cycle, so bubbles collapse under backpressure
    logic [N_ST-1:0] valid_reg;
    logic [N_ST-1:0] valid_next;
    logic [N_ST-1:0] rdy;
    logic [N_ST-1:0] ld;
    logic [N_ST-1:0] go;

    always_comb begin
        for (int k = N_ST - 1; k >= 0; k--) begin
            if (k == N_ST - 1) begin
                go[k] = valid_reg[k] & m_tready;
            end else begin
                go[k] = valid_reg[k] & rdy[k+1];
            end
            rdy[k] = ~valid_reg[k] | go[k];
        end
        for (int k = 0; k < N_ST; k++) begin
            if (k == 0) begin
                ld[k] = s_tvalid & rdy[k];
            end else begin
                ld[k] = valid_reg[k-1] & rdy[k];
            end
            valid_next[k] = ld[k] | (valid_reg[k] & ~go[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[ST_IN];
    assign m_tvalid = valid_reg[ST_OUT];

    // ---------------- configuration ----------------
    logic [PHASE_W-1:0] ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ratio_reg <= cfg_data;
        end
    end

    // ---------------- input register ----------------
    logic [WORD_W-1:0] word_reg;

    always_ff @(posedge aclk) begin
        if (ld[ST_IN]) begin
            word_reg <= s_tdata[WORD_W-1:0];
        end
    end

    // ---------------- front section and phase ----------------
    logic signed [FRONT_W-1:0] fout_reg;

    bcic_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ld[ST_FRONT]),
        .word     (word_reg),
        .fout_reg (fout_reg)
    );

    // phase counter advances once per word; equality match with the ratio
    // decides the decimation point, so a ratio of zero matches after a wrap
    logic [PHASE_W-1:0] cnt_reg;
    logic [PHASE_W-1:0] cnt_inc;
    logic               dec_hit;
    logic [PHASE_W-1:0] cnt_next;

    assign cnt_inc  = cnt_reg + PHASE_W'(1);
    assign dec_hit  = (cnt_inc == ratio_reg);
    assign cnt_next = dec_hit ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ld[ST_FRONT]) begin
            cnt_reg <= cnt_next;
        end
    end

    // phase and decimation flag travel with the word
    logic [PHASE_W-1:0] phase_reg [ST_FRONT:ST_OUT];
    logic               dec_reg   [ST_FRONT:ST_OUT];

    always_ff @(posedge aclk) begin
        if (ld[ST_FRONT]) begin
            phase_reg[ST_FRONT] <= cnt_next;
            dec_reg[ST_FRONT]   <= dec_hit;
        end
        for (int k = ST_FRONT + 1; k <= ST_OUT; k++) begin
            if (ld[k]) begin
                phase_reg[k] <= phase_reg[k-1];
                dec_reg[k]   <= dec_reg[k-1];
            end
        end
    end

    // ---------------- integrators ----------------
    // integrator j updates when its stage takes the word; the one before it
    // already holds its value for that same word
    logic [ACC_WIDTH-1:0] integ_reg [N_STAGES];
    logic [ACC_WIDTH-1:0] fout_ext;

    assign fout_ext = {{(ACC_WIDTH-FRONT_W){fout_reg[FRONT_W-1]}}, fout_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < N_STAGES; j++) begin
                integ_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < N_STAGES; j++) begin
                if (ld[ST_INT+j]) begin
                    if (j == 0) begin
                        integ_reg[j] <= integ_reg[j] + fout_ext;
                    end else begin
                        integ_reg[j] <= integ_reg[j] + integ_reg[j-1];
                    end
                end
            end
        end
    end

    // ---------------- combs ----------------
    // combs run only on words that hit the decimation point
    logic [ACC_WIDTH-1:0] cdly_reg [N_STAGES];
    logic [ACC_WIDTH-1:0] comb_reg [N_STAGES-1];
    logic [ACC_WIDTH-1:0] comb_in  [N_STAGES];
    logic [ACC_WIDTH-1:0] comb_out [N_STAGES];
    logic                 comb_en  [N_STAGES];

    always_comb begin
        for (int j = 0; j < N_STAGES; j++) begin
            if (j == 0) begin
                comb_in[j] = integ_reg[N_STAGES-1];
            end else begin
                comb_in[j] = comb_reg[j-1];
            end
            comb_out[j] = comb_in[j] - cdly_reg[j];
            comb_en[j]  = ld[ST_COMB+j] & dec_reg[ST_COMB+j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < N_STAGES; j++) begin
                cdly_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < N_STAGES; j++) begin
                if (comb_en[j]) begin
                    cdly_reg[j] <= comb_in[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < N_STAGES - 1; j++) begin
            if (comb_en[j]) begin
                comb_reg[j] <= comb_out[j];
            end
        end
    end

    // ---------------- output ----------------
    // last comb result is sign extended, sliced and zeroed on words with no sample
    logic signed [EXT_W-1:0]    last_ext;
    logic [SAMPLE_W-1:0]        sample_next;
    logic [SAMPLE_W-1:0]        sample_reg;

    assign last_ext    = EXT_W'(signed'(comb_out[N_STAGES-1]));
    assign sample_next = dec_reg[ST_OUT-1] ? last_ext[OUT_SHIFT +: SAMPLE_W] : '0;

    always_ff @(posedge aclk) begin
        if (ld[ST_OUT]) begin
            sample_reg <= sample_next;
        end
    end

    assign m_tdata = {phase_reg[ST_OUT], sample_reg};
    assign m_tuser = dec_reg[ST_OUT];

endmodule

`default_nettype wire

/* rtl/core/bcic_front.sv */
`default_nettype none

module bcic_front import bcic_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      load,
    input  wire logic [WORD_W-1:0]         word,
    output logic signed [FRONT_W-1:0]      fout_reg
);

    logic [FRONT_W-1:0] acc_reg;
    logic [FRONT_W-1:0] dly_reg;
    logic [FRONT_W-1:0] acc_next;
    logic [FRONT_W-1:0] fout_next;

    // one-stage integrator and comb on wrapped registers
    assign acc_next  = acc_reg + word_diff(word);
    assign fout_next = acc_next - dly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            dly_reg <= '0;
        end else if (load) begin
            acc_reg <= acc_next;
            dly_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            fout_reg <= signed'(fout_next);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bcic_checker.sv */
`default_nettype none

module bcic_assertions (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // no sample: sample field is zero
    a_zero_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("nonzero sample on a word without a sample");

    // a sample is emitted only with the phase at zero
    a_phase_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:16] == 16'd0)
        else $error("sample emitted with nonzero phase");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind bitstream_cic_decimator bcic_assertions u_bcic_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/bcic_checker.sv */
`timescale 1ns / 1ps

// watches the three channels of the decimator, predicts every result word and compares
module bcic_checker import bcic_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [PHASE_W-1:0]  cfg_data,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [15:0]         s_tdata,   // [13:0] sample_word, [15:14] zero
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [31:0]         m_tdata,   // [15:0] filtered_sample, [31:16] phase
    input  wire logic                m_tuser,   // [0] sample_valid
    output int                       errors,
    output int                       pending,
    output int                       samples_seen
);

    localparam int ACC_W = ACC_WIDTH_DEF;
    localparam int SHIFT = OUT_SHIFT_DEF;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic [PHASE_W-1:0]         phase;
    } cic_result_t;

    cic_result_t        predicted_results[$];

    logic [PHASE_W-1:0] ratio_q;
    logic [FRONT_W-1:0] front_sum;
    logic [FRONT_W-1:0] front_prev;
    logic [ACC_W-1:0]   integ_q [N_STAGES];
    logic [ACC_W-1:0]   comb_q  [N_STAGES];
    logic [PHASE_W-1:0] phase_q;

    // advances the filter model by one input word
    function automatic cic_result_t predict_word(input logic [WORD_W-1:0] w);
        int                 n_pos;
        int                 n_neg;
        logic [FRONT_W-1:0] d7;
        logic [FRONT_W-1:0] front_out;
        logic [ACC_W-1:0]   x;
        logic [ACC_W-1:0]   c;
        logic signed [63:0] wide;
        cic_result_t        r;
        n_pos = 0;
        n_neg = 0;
        for (int k = 0; k < HALF_W; k++) begin
            n_pos += int'(w[2*k]);
            n_neg += int'(w[2*k+1]);
        end
        d7 = FRONT_W'(2 * (n_pos - n_neg));
        front_sum  = front_sum + d7;
        front_out  = front_sum - front_prev;
        front_prev = front_sum;
        x = {{(ACC_W-FRONT_W){front_out[FRONT_W-1]}}, front_out};
        for (int j = 0; j < N_STAGES; j++) begin
            integ_q[j] = integ_q[j] + x;
            x = integ_q[j];
        end
        phase_q   = phase_q + 1'b1;
        r.valid   = 1'b0;
        r.sample  = '0;
        if (phase_q == ratio_q) begin
            phase_q = '0;
            x = integ_q[N_STAGES-1];
            for (int j = 0; j < N_STAGES; j++) begin
                c = x - comb_q[j];
                comb_q[j] = x;
                x = c;
            end
            // bits past the accumulator read as sign copies
            wide     = {{(64-ACC_W){x[ACC_W-1]}}, x};
            wide     = wide >>> SHIFT;
            r.valid  = 1'b1;
            r.sample = wide[SAMPLE_W-1:0];
        end
        r.phase = phase_q;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        cic_result_t got;
        cic_result_t want;
        if (!aresetn) begin
            predicted_results.delete();
            ratio_q      = RATIO_RESET;
            front_sum    = '0;
            front_prev   = '0;
            phase_q      = '0;
            for (int j = 0; j < N_STAGES; j++) begin
                integ_q[j] = '0;
                comb_q[j]  = '0;
            end
            errors       = 0;
            pending      = 0;
            samples_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.valid  = m_tuser;
                got.sample = m_tdata[SAMPLE_W-1:0];
                got.phase  = m_tdata[SAMPLE_W +: PHASE_W];
                if (predicted_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, got valid %0b sample %0d phase %0d",
                             $time, got.valid, got.sample, got.phase);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.valid !== want.valid) begin
                        errors++;
                        $display("%0t: sample_valid expected %0b, got %0b",
                                 $time, want.valid, got.valid);
                    end
                    if (got.sample !== want.sample) begin
                        errors++;
                        $display("%0t: filtered_sample expected %0d, got %0d",
                                 $time, want.sample, got.sample);
                    end
                    if (got.phase !== want.phase) begin
                        errors++;
                        $display("%0t: phase expected %0d, got %0d",
                                 $time, want.phase, got.phase);
                    end
                    if (want.valid) samples_seen++;
                end
            end
            if (cfg_valid && cfg_ready) ratio_q = cfg_data;
            if (s_tvalid && s_tready)
                predicted_results.push_back(predict_word(s_tdata[WORD_W-1:0]));
            pending = predicted_results.size();
        end
    end

endmodule

/* tb/tb_bitstream_cic_decimator.sv */
`timescale 1ns / 1ps

module tb_bitstream_cic_decimator;
    import bcic_pkg::*;

    localparam int DRAIN_SLACK  = 12;      // a little over the pipeline latency
    localparam int RANDOM_WORDS = 1450;    // random part, short phases with small ratios
    localparam int LONG_WORDS   = 24;      // words sent after the ratio drops to zero
    localparam int DRAIN_LIMIT  = 20000;   // cycles allowed for the last results to arrive

    localparam logic [WORD_W-1:0] EVEN_BITS = 14'h1555;   // every positive sample set
    localparam logic [WORD_W-1:0] ODD_BITS  = 14'h2AAA;   // every negative sample set

    // how the content of an input word is drawn
    typedef enum int {WS_UNIFORM, WS_RISING, WS_FALLING, WS_SPARSE} word_style_e;
    // how the receiver holds back result words
    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BLOCKS} rx_mode_e;

    // every input of the block starts at a known value
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [PHASE_W-1:0]  cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic [15:0]         s_tdata   = '0;    // [13:0] sample_word, [15:14] zero
    logic                m_tready  = 1'b0;

    wire logic           cfg_ready;
    wire logic           s_tready;
    wire logic           m_tvalid;
    wire logic [31:0]    m_tdata;           // [15:0] filtered_sample, [31:16] phase
    wire logic           m_tuser;           // [0] sample_valid

    int errors;
    int pending;
    int samples_seen;

    // stimulus bookkeeping
    int                  words_sent   = 0;
    int                  ratio_writes = 0;
    int                  burst_left   = 0;
    bit                  tx_steady    = 1'b0;   // sender without gaps
    bit                  rx_steady    = 1'b0;   // receiver always ready
    bit                  rx_light     = 1'b0;   // receiver without long stalls
    logic [PHASE_W-1:0]  cur_ratio    = RATIO_RESET;
    logic [PHASE_W-1:0]  frame_pos    = '0;     // words since the last decimated sample

    always #10 aclk = ~aclk;

    bitstream_cic_decimator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bcic_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .samples_seen (samples_seen)
    );

    // hard stop in case a handshake never completes
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: its own stall pattern, in a mode that is redrawn at random
    int       rx_tick = 0;
    rx_mode_e rx_mode = RX_OPEN;

    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 48 == 0)
            rx_mode = rx_mode_e'($urandom_range(0, rx_light ? 2 : 3));
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_tready <= (rx_tick % 3 != 0);
                default:     m_tready <= (rx_tick % 16 >= 6);   // stalls in blocks
            endcase
        end
    end

    // draws one word; the biased styles push the integrators hard one way
    function automatic logic [WORD_W-1:0] make_word(input word_style_e style);
        logic [WORD_W-1:0] noise;
        noise = WORD_W'($urandom) & WORD_W'($urandom) & WORD_W'($urandom);
        case (style)
            WS_RISING:  return EVEN_BITS ^ noise;
            WS_FALLING: return ODD_BITS ^ noise;
            WS_SPARSE:  return WORD_W'($urandom) & WORD_W'($urandom);
            default:    return WORD_W'($urandom);
        endcase
    endfunction

    // sends one word; called and returning at a falling edge, bursts and gaps inside
    task automatic push_word(input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {{(16-WORD_W){1'b0}}, w};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
        // track where the counter stands so later ratio writes stay above it
        frame_pos = frame_pos + 1'b1;
        if (frame_pos == cur_ratio) frame_pos = '0;
    endtask

    // sender holds off until every predicted result word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    // ratio writes happen only with the pipeline empty
    task automatic write_ratio(input logic [PHASE_W-1:0] r);
        drain_results();
        repeat (DRAIN_SLACK) @(negedge aclk);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_ratio = r;
        ratio_writes++;
    endtask

    initial begin
        int                 random_sent;
        int                 len;
        int                 sel;
        int                 waited;
        logic [PHASE_W-1:0] r;
        word_style_e        style;

        random_sent = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes at the reset ratio of one
        push_word('0);
        push_word('1);
        push_word(EVEN_BITS);           // largest positive difference
        push_word(ODD_BITS);            // largest negative difference
        push_word(14'h0001);
        push_word(14'h2000);
        push_word(EVEN_BITS);
        push_word(EVEN_BITS);

        // steady positive input, two full frames of three
        write_ratio(16'd3);
        repeat (6) push_word(EVEN_BITS);

        // largest ratio, then lowered mid-count from 65535 to 7 while the count is at 3
        write_ratio(16'hFFFF);
        repeat (3) push_word(WORD_W'($urandom));
        write_ratio(16'd7);
        repeat (4) push_word(EVEN_BITS);

        // random phases: new ratio, word style and idling per phase
        while (random_sent < RANDOM_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)      r = PHASE_W'($urandom_range(1, 8));
            else if (sel < 80) r = PHASE_W'($urandom_range(9, 64));
            else if (sel < 93) r = PHASE_W'($urandom_range(65, 400));
            else               r = RATIO_RESET;
            if (r <= frame_pos) r = frame_pos + 1'b1;
            write_ratio(r);
            style     = word_style_e'($urandom_range(0, 3));
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady <= tx_steady;
            len = $urandom_range(40, 180);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 4) == 0) push_word(make_word(WS_UNIFORM));
                else                           push_word(make_word(style));
                if ($urandom_range(0, 299) == 0) drain_results();
            end
            random_sent += len;
        end

        // ratio dropped to zero below the running count: the counter runs on unmatched
        tx_steady = 1'b1;
        rx_steady <= 1'b0;
        rx_light  <= 1'b1;
        write_ratio(16'd10);
        repeat (6) push_word(make_word(WS_UNIFORM));
        write_ratio('0);
        for (int i = 0; i < LONG_WORDS; i++) push_word(make_word(WS_UNIFORM));

        // let the pipeline empty, then watch a while longer for stray words
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (DRAIN_SLACK) @(negedge aclk);

        $display("run covered %0d input words over %0d ratio settings (1, 3, 65535, 0 and random)",
                 words_sent, ratio_writes);
        $display("%0d decimated samples checked, %0d mismatches", samples_seen, errors);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/bcic_pkg.sv
rtl/core/bcic_front.sv
rtl/core/bitstream_cic_decimator.sv
rtl/core/bcic_checker.sv
tb/bcic_checker.sv
tb/tb_bitstream_cic_decimator.sv
